// ===== hdl/ctn_pkg.sv =====
// ----------------------------------------------------------------------------
// ctn_pkg
// Types, constants and table functions shared by the calendar time
// normalizer, its weekday reduction unit and its checker.
// ----------------------------------------------------------------------------
package ctn_pkg;

  localparam logic [15:0] MIN_YEAR   = 16'd1900;
  localparam logic [7:0]  MONTH_MAX  = 8'd11;
  localparam logic [7:0]  HOUR_MAX   = 8'd23;
  localparam logic [7:0]  MINUTE_MAX = 8'd59;
  localparam logic [7:0]  SECOND_MAX = 8'd59;
  localparam logic [3:0]  MONTH_FEB  = 4'd1;
  localparam logic [4:0]  FEB_LEAP_LEN = 5'd29;

  // Division by 100 is done as (y / 4) / 25, with 1/25 taken as 5243 / 2^17.
  // The quarter year is below 2^14, where this reciprocal is exact.
  localparam int unsigned QUARTER_W = 14;
  localparam int unsigned RECIP_W   = 13;
  localparam int unsigned PROD_W    = QUARTER_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 17;
  localparam int unsigned CENT_W    = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;

  // Width of the weekday congruence sum before reduction modulo 7.
  localparam int unsigned SUM_W = 17;

  typedef struct packed {
    logic [15:0] year_in;
    logic [7:0]  month_in;
    logic [7:0]  day_in;
    logic [7:0]  hour_in;
    logic [7:0]  minute_in;
    logic [7:0]  second_in;
  } date_in_t;

  typedef struct packed {
    logic [15:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [2:0]  weekday_out;
  } date_out_t;

  // Days in a month of a common year, month zero-based.
  function automatic logic [4:0] month_base_len(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd1:    len = 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Month term of the congruence: 2m + 6(m+1)/10, where January and
  // February count as months 13 and 14.
  function automatic logic [5:0] month_offset(input logic [3:0] month);
    logic [5:0] ofs;
    case (month)
      4'd0:    ofs = 6'd34;
      4'd1:    ofs = 6'd37;
      4'd2:    ofs = 6'd8;
      4'd3:    ofs = 6'd11;
      4'd4:    ofs = 6'd13;
      4'd5:    ofs = 6'd16;
      4'd6:    ofs = 6'd18;
      4'd7:    ofs = 6'd21;
      4'd8:    ofs = 6'd24;
      4'd9:    ofs = 6'd26;
      4'd10:   ofs = 6'd29;
      default: ofs = 6'd31;
    endcase
    return ofs;
  endfunction

endpackage

// ===== hdl/ctn_mod7.sv =====
// ----------------------------------------------------------------------------
// ctn_mod7
// Reduces the weekday congruence sum modulo 7 by folding octal digits.
// ----------------------------------------------------------------------------
module ctn_mod7 (
  input  logic [ctn_pkg::SUM_W-1:0] value,
  output logic [2:0]                rem
);

  logic [5:0] fold1;
  logic [3:0] fold2;

  // Since 8 is 1 modulo 7, the sum of the octal digits keeps the residue.
  always_comb begin
    fold1 = 6'(value[2:0]) + 6'(value[5:3]) + 6'(value[8:6])
          + 6'(value[11:9]) + 6'(value[14:12]) + 6'(value[16:15]);
    fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
    if (fold2 >= 4'd7) begin
      rem = 3'(fold2 - 4'd7);
    end else begin
      rem = fold2[2:0];
    end
  end

endmodule

// ===== hdl/calendar_time_normalizer.sv =====
// ----------------------------------------------------------------------------
// calendar_time_normalizer
// Clamps a date-time to valid ranges and computes its day of the week.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction enters when start is high and busy is low; item carries
//   year, zero-based month, day, hour, minute and second. busy is high only
//   while rst is held, so a new item can be started in every cycle.
//   Each result appears on result for one cycle with done high, once it
//   has passed all stages; results leave in the order items entered.
//   The receiver cannot stall the block, and nothing here stalls either.
//   Sustained rate is one item per cycle. The five stages are: clamping,
//   the two divide-by-100 reciprocal multiplies, the leap-year test with
//   day clamp and year terms, the congruence sum, and its modulo-7 fold.
//   Reset clears the valid bits of all stages, so items in flight are
//   dropped and done stays low until new items come out.
// ----------------------------------------------------------------------------
module calendar_time_normalizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  ctn_pkg::date_in_t  item,
  output logic               done,
  output ctn_pkg::date_out_t result
);

  logic [4:0] vld;

  // Stage 1: clamped fields and congruence year.
  logic [15:0] year1, yz1;
  logic [3:0]  month1;
  logic [7:0]  day1;
  logic [4:0]  hour1;
  logic [5:0]  minute1, second1;
  logic [15:0] year_c;
  logic [3:0]  month_c;

  // Stage 2: centuries of both years and month term.
  logic [15:0] year2, yz2;
  logic [3:0]  month2;
  logic [7:0]  day2;
  logic [4:0]  hour2;
  logic [5:0]  minute2, second2;
  logic [5:0]  moff2;
  logic [ctn_pkg::CENT_W-1:0] qy2, qz2;
  logic [ctn_pkg::PROD_W-1:0] prod_y, prod_z;

  // Stage 3: clamped day and year terms of the congruence.
  logic [15:0] year3;
  logic [3:0]  month3;
  logic [4:0]  day3;
  logic [4:0]  hour3;
  logic [5:0]  minute3, second3;
  logic [5:0]  moff3;
  logic [ctn_pkg::SUM_W-1:0] ysum3;
  logic [ctn_pkg::QUARTER_W-1:0] cent25;
  logic div100, div400, leap;
  logic [4:0] mlen, day_c;
  logic [ctn_pkg::SUM_W-1:0] ysum_c;

  // Stage 4: full congruence sum.
  logic [15:0] year4;
  logic [3:0]  month4;
  logic [4:0]  day4;
  logic [4:0]  hour4;
  logic [5:0]  minute4, second4;
  logic [ctn_pkg::SUM_W-1:0] total4;

  logic [2:0] weekday_c;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start};
    end
  end

  always_comb begin
    year_c  = (item.year_in < ctn_pkg::MIN_YEAR) ? ctn_pkg::MIN_YEAR : item.year_in;
    month_c = (item.month_in > ctn_pkg::MONTH_MAX) ? ctn_pkg::MONTH_MAX[3:0]
                                                  : item.month_in[3:0];
  end

  always_ff @(posedge clk) begin
    year1   <= year_c;
    // January and February belong to the previous year; the year is at
    // least 1900 here, so the decrement never wraps.
    yz1     <= (month_c < 4'd2) ? year_c - 16'd1 : year_c;
    month1  <= month_c;
    day1    <= item.day_in;
    hour1   <= (item.hour_in > ctn_pkg::HOUR_MAX) ? ctn_pkg::HOUR_MAX[4:0]
                                                 : item.hour_in[4:0];
    minute1 <= (item.minute_in > ctn_pkg::MINUTE_MAX) ? ctn_pkg::MINUTE_MAX[5:0]
                                                     : item.minute_in[5:0];
    second1 <= (item.second_in > ctn_pkg::SECOND_MAX) ? ctn_pkg::SECOND_MAX[5:0]
                                                     : item.second_in[5:0];
  end

  always_comb begin
    prod_y = ctn_pkg::PROD_W'(year1[15:2]) * ctn_pkg::PROD_W'(ctn_pkg::RECIP_25);
    prod_z = ctn_pkg::PROD_W'(yz1[15:2]) * ctn_pkg::PROD_W'(ctn_pkg::RECIP_25);
  end

  always_ff @(posedge clk) begin
    year2   <= year1;
    yz2     <= yz1;
    month2  <= month1;
    day2    <= day1;
    hour2   <= hour1;
    minute2 <= minute1;
    second2 <= second1;
    moff2   <= ctn_pkg::month_offset(month1);
    qy2     <= prod_y[ctn_pkg::PROD_W-1:ctn_pkg::RECIP_SHIFT];
    qz2     <= prod_z[ctn_pkg::PROD_W-1:ctn_pkg::RECIP_SHIFT];
  end

  always_comb begin
    cent25 = ctn_pkg::QUARTER_W'({qy2, 4'b0000}) + ctn_pkg::QUARTER_W'({qy2, 3'b000})
           + ctn_pkg::QUARTER_W'(qy2);
    // A year is a multiple of 100 when it is a multiple of 4 whose quarter
    // is a multiple of 25.
    div100 = (year2[1:0] == 2'b00) && (year2[15:2] == cent25);
    div400 = div100 && (qy2[1:0] == 2'b00);
    leap   = ((year2[1:0] == 2'b00) && !div100) || div400;
    if ((month2 == ctn_pkg::MONTH_FEB) && leap) begin
      mlen = ctn_pkg::FEB_LEAP_LEN;
    end else begin
      mlen = ctn_pkg::month_base_len(month2);
    end
    day_c  = (day2 > 8'(mlen)) ? mlen : day2[4:0];
    ysum_c = ctn_pkg::SUM_W'(yz2) + ctn_pkg::SUM_W'(yz2[15:2])
           + ctn_pkg::SUM_W'(qz2[ctn_pkg::CENT_W-1:2]) - ctn_pkg::SUM_W'(qz2);
  end

  always_ff @(posedge clk) begin
    year3   <= year2;
    month3  <= month2;
    day3    <= day_c;
    hour3   <= hour2;
    minute3 <= minute2;
    second3 <= second2;
    moff3   <= moff2;
    ysum3   <= ysum_c;
  end

  always_ff @(posedge clk) begin
    year4   <= year3;
    month4  <= month3;
    day4    <= day3;
    hour4   <= hour3;
    minute4 <= minute3;
    second4 <= second3;
    total4  <= ysum3 + ctn_pkg::SUM_W'(day3) + ctn_pkg::SUM_W'(moff3)
             + ctn_pkg::SUM_W'(1);
  end

  ctn_mod7 u_mod7 (
    .value (total4),
    .rem   (weekday_c)
  );

  always_ff @(posedge clk) begin
    result.year_out    <= year4;
    result.month_out   <= month4;
    result.day_out     <= day4;
    result.hour_out    <= hour4;
    result.minute_out  <= minute4;
    result.second_out  <= second4;
    result.weekday_out <= weekday_c;
  end

  assign done = vld[4];

endmodule

// ===== hdl/ctn_checker.sv =====
// ----------------------------------------------------------------------------
// ctn_checker
// Port-level checks of the calendar time normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module ctn_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input ctn_pkg::date_in_t  item,
  input logic               done,
  input ctn_pkg::date_out_t result
);

  // Every accepted transaction yields its result.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("accepted transaction produced no result");

  // No result appears without a matching accepted transaction.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without matching transaction");

  a_ranges: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.year_out >= ctn_pkg::MIN_YEAR) && (result.month_out <= 4'd11)
             && (result.weekday_out <= 3'd6)
             && !((result.month_out == ctn_pkg::MONTH_FEB) && (result.day_out > 5'd29)))
    else $error("result field out of range");

  a_hour: assert property (@(posedge clk) disable iff (rst)
    done |-> (($past(item.hour_in, 5) > ctn_pkg::HOUR_MAX)
              ? (result.hour_out == ctn_pkg::HOUR_MAX[4:0])
              : (8'(result.hour_out) == $past(item.hour_in, 5))))
    else $error("hour does not follow its transaction");

endmodule

bind calendar_time_normalizer ctn_checker u_ctn_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for calendar_time_normalizer. Dates are sent in random
// bursts, and every result is compared field by field with an independent
// clamp and weekday calculation.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned RANDOM_DATES = 1230;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned FEBRUARY     = 1;
  localparam int unsigned LAST_MONTH   = 11;

  typedef struct {
    ctn_pkg::date_in_t date;
    bit                drain_first;
  } date_request_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  ctn_pkg::date_in_t  item = '0;
  logic               done;
  ctn_pkg::date_out_t result;

  date_request_t      dates_to_send[$];
  ctn_pkg::date_out_t predicted_dates[$];

  ctn_pkg::date_out_t accepted_date;
  date_request_t      next_request;

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned dates_checked = 0;
  int unsigned clamped_days = 0;
  int unsigned drain_pauses = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  calendar_time_normalizer dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Clamps every field and works out the weekday with the congruence that
  // treats January and February as months 13 and 14 of the year before.
  function automatic ctn_pkg::date_out_t normalize_date(input ctn_pkg::date_in_t d);
    int unsigned yr, mon, dy, mlen, zm, zy, total;
    ctn_pkg::date_out_t r;
    yr  = (d.year_in < 16'd1900) ? 1900 : d.year_in;
    mon = (d.month_in > LAST_MONTH) ? LAST_MONTH : d.month_in;
    case (mon)
      1:        mlen = 28;
      3, 5, 8, 10: mlen = 30;
      default:  mlen = 31;
    endcase
    if (mon == FEBRUARY && ((yr % 400 == 0) || (yr % 100 != 0 && yr % 4 == 0)))
      mlen = 29;
    dy = (d.day_in > mlen) ? mlen : d.day_in;
    zm = mon + 1;
    zy = yr;
    if (zm < 3) begin
      zm = zm + 12;
      zy = zy - 1;
    end
    total = dy + 2 * zm + (6 * (zm + 1)) / 10 + zy + zy / 4 - zy / 100 + zy / 400 + 1;
    r.year_out    = yr[15:0];
    r.month_out   = mon[3:0];
    r.day_out     = dy[4:0];
    r.hour_out    = (d.hour_in > 8'd23) ? 5'd23 : d.hour_in[4:0];
    r.minute_out  = (d.minute_in > 8'd59) ? 6'd59 : d.minute_in[5:0];
    r.second_out  = (d.second_in > 8'd59) ? 6'd59 : d.second_in[5:0];
    r.weekday_out = 3'(total % 7);
    return r;
  endfunction

  task automatic queue_date(input int unsigned yr, input int unsigned mon,
                            input int unsigned dy, input int unsigned hr,
                            input int unsigned mi, input int unsigned se,
                            input bit drain);
    date_request_t req;
    req.date.year_in   = yr[15:0];
    req.date.month_in  = mon[7:0];
    req.date.day_in    = dy[7:0];
    req.date.hour_in   = hr[7:0];
    req.date.minute_in = mi[7:0];
    req.date.second_in = se[7:0];
    req.drain_first    = drain;
    dates_to_send.push_back(req);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: records each accepted transaction, then presents the next date
  // unless the burst pattern or a drain request holds it back.
  always @(posedge clk) begin
    if (start && !busy) begin
      accepted_date = normalize_date(item);
      predicted_dates.push_back(accepted_date);
      if (8'(accepted_date.day_out) != item.day_in)
        clamped_days++;
    end
    if (start && busy) begin
      start <= 1'b1;
    end else if (rst || dates_to_send.size() == 0) begin
      start <= 1'b0;
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (dates_to_send[0].drain_first && predicted_dates.size() != 0) begin
      start <= 1'b0;
    end else begin
      if (dates_to_send[0].drain_first)
        drain_pauses++;
      next_request = dates_to_send.pop_front();
      item <= next_request.date;
      start <= 1'b1;
      if (burst_left > 1) begin
        burst_left <= burst_left - 1;
      end else begin
        // Mostly short bursts, now and then a long one with no gaps at all.
        burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      end
    end
  end

  // Monitor: done is a one-cycle strobe, so every result is taken as it comes.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (predicted_dates.size() == 0) begin
        $error("Result with no transaction outstanding: year %0d month %0d day %0d",
               result.year_out, result.month_out, result.day_out);
        mismatches++;
      end else begin
        ctn_pkg::date_out_t want;
        want = predicted_dates.pop_front();
        check_field("year_out", want.year_out, result.year_out);
        check_field("month_out", want.month_out, result.month_out);
        check_field("day_out", want.day_out, result.day_out);
        check_field("hour_out", want.hour_out, result.hour_out);
        check_field("minute_out", want.minute_out, result.minute_out);
        check_field("second_out", want.second_out, result.second_out);
        check_field("weekday_out", want.weekday_out, result.weekday_out);
        dates_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, predicted_dates.size());
      $display("calendar_time_normalizer test failed");
      $finish;
    end
  end

  initial begin
    int unsigned yr, mon, dy, hr, mi, se;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Field extremes and the years below the floor.
    queue_date(0, 0, 1, 0, 0, 0, 1'b0);
    queue_date(65535, 255, 255, 255, 255, 255, 1'b0);
    queue_date(1899, 5, 15, 12, 30, 30, 1'b0);
    queue_date(65535, 0, 31, 23, 59, 59, 1'b0);
    queue_date(65535, 1, 29, 24, 60, 60, 1'b0);
    // February in century, quad-century and ordinary leap years.
    queue_date(1900, 1, 29, 0, 0, 0, 1'b0);
    queue_date(2000, 1, 29, 1, 1, 1, 1'b0);
    queue_date(2000, 1, 30, 2, 2, 2, 1'b0);
    queue_date(2004, 1, 31, 3, 3, 3, 1'b0);
    queue_date(2100, 1, 29, 4, 4, 4, 1'b0);
    // Day zero passes through unchanged, and month 12 is clamped to December.
    queue_date(2000, 0, 0, 0, 0, 0, 1'b0);
    queue_date(2023, 2, 0, 5, 6, 7, 1'b0);
    queue_date(2000, 12, 31, 23, 59, 59, 1'b0);
    // Day 31 in every month of a leap year.
    for (int m = 0; m < 12; m++)
      queue_date(2024, m, 31, m * 2, m * 5, 59 - m, 1'b0);

    for (int n = 0; n < RANDOM_DATES; n++) begin
      case ($urandom_range(0, 4))
        0: yr = $urandom_range(0, 65535);
        1: yr = $urandom_range(1890, 2200);
        2: yr = 100 * $urandom_range(18, 655);
        3: yr = 4 * $urandom_range(470, 16383);
        default: yr = 400 * $urandom_range(0, 163);
      endcase
      mon = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 11);
      case ($urandom_range(0, 3))
        0: dy = $urandom_range(27, 32);
        1: dy = $urandom_range(0, 255);
        default: dy = $urandom_range(0, 31);
      endcase
      hr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
      mi = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 60);
      se = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 60);
      queue_date(yr, mon, dy, hr, mi, se, (n % 300) == 0);
    end

    while (dates_to_send.size() != 0 || start)
      @(posedge clk);
    while (predicted_dates.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d dates in %0d cycles; %0d had their day clamped.",
             dates_checked, cycle_count, clamped_days);
    $display("The sender drained the pipeline %0d times between bursts.", drain_pauses);
    if (mismatches == 0)
      $display("calendar_time_normalizer test passed");
    else
      $display("calendar_time_normalizer test failed");
    $finish;
  end

endmodule
